### hdl/nearest_box_classifier_unit_defines.svh
// Assertion macros shared by the classifier.
`ifndef NEAREST_BOX_CLASSIFIER_UNIT_DEFINES_SVH
`define NEAREST_BOX_CLASSIFIER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/nbc_pkg.sv
package nbc_pkg;

	localparam int unsigned NUM_ENTRIES = 32;
	localparam int unsigned COORD_BITS  = 16;
	localparam int unsigned NUM_AXES    = 6;

	localparam int unsigned IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int unsigned CMP_W  = (IDX_W > 5) ? IDX_W : 5;
	localparam int unsigned USE_W  = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;
	localparam int unsigned GAP_W  = COORD_BITS;
	localparam int unsigned SQ_W   = 2 * COORD_BITS;
	localparam int unsigned PAIR_W = SQ_W + 1;
	localparam int unsigned DIST_W = SQ_W + 3;

	// Request codes.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Register indexes.
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic REG_FALLBACK_CLASS = 1'b1;

	// Axis codes.
	localparam logic [2:0] AXIS_TEMPERATURE = 3'd0;
	localparam logic [2:0] AXIS_HUMIDITY    = 3'd1;
	localparam logic [2:0] AXIS_CONTINENT   = 3'd2;
	localparam logic [2:0] AXIS_EROSION     = 3'd3;
	localparam logic [2:0] AXIS_RIDGE       = 3'd4;
	localparam logic [2:0] AXIS_WEIRD       = 3'd5;

	// A load beat carries its bound pair in the first two coordinate slots.
	localparam int unsigned SLOT_LOW  = 0;
	localparam int unsigned SLOT_HIGH = 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [GAP_W-1:0]  gap_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [PAIR_W-1:0] pair_t;
	typedef logic [DIST_W-1:0] dist_t;

	// One beat travelling along the row of cells.
	typedef struct packed {
		logic                      load;
		logic [4:0]                entry;
		logic [2:0]                axis;
		coord_t [NUM_AXES-1:0]     coord;
	} item_t;

	// Running best match handed from cell to cell.
	typedef struct packed {
		logic             found;
		dist_t            total;
		logic [IDX_W-1:0] idx;
	} best_t;

endpackage

### hdl/nbc_cell.sv
module nbc_cell
	import nbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic             in_use,
	input  logic             item_vld_in,
	input  item_t            item_in,
	input  best_t            best_in,
	output logic             item_vld_out,
	output item_t            item_out,
	output logic             best_vld_out,
	output best_t            best_out
);

	logic   item_vld_q;
	item_t  item_q;
	coord_t lo_q [NUM_AXES];
	coord_t hi_q [NUM_AXES];

	logic  qry_s1, qry_s2, qry_s3;
	gap_t  gap_s1  [NUM_AXES];
	sq_t   sq_s2   [NUM_AXES];
	pair_t pair_s3 [NUM_AXES/2];

	logic  best_vld_q;
	best_t best_q;

	gap_t                  gap_d [NUM_AXES];
	logic [COORD_BITS:0]   dlo   [NUM_AXES];
	logic [COORD_BITS:0]   dhi   [NUM_AXES];
	dist_t                 sum;
	logic                  take;
	logic                  wr_hit;

	assign wr_hit = item_vld_q && (item_q.load == REQ_LOAD) &&
	                (CMP_W'(item_q.entry) == CMP_W'(cell_idx));

	// Distance outside the bound pair; with an inverted pair no coordinate lies inside.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			dlo[a] = {lo_q[a][COORD_BITS-1], lo_q[a]} -
			         {item_q.coord[a][COORD_BITS-1], item_q.coord[a]};
			dhi[a] = {item_q.coord[a][COORD_BITS-1], item_q.coord[a]} -
			         {hi_q[a][COORD_BITS-1], hi_q[a]};
			if ($signed(item_q.coord[a]) < $signed(lo_q[a])) begin
				gap_d[a] = dlo[a][GAP_W-1:0];
			end else if ($signed(item_q.coord[a]) > $signed(hi_q[a])) begin
				gap_d[a] = dhi[a][GAP_W-1:0];
			end else begin
				gap_d[a] = '0;
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int p = 0; p < NUM_AXES/2; p++) begin
			sum = sum + DIST_W'(pair_s3[p]);
		end
		take = in_use && (!best_in.found || (sum < best_in.total));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			qry_s1     <= 1'b0;
			qry_s2     <= 1'b0;
			qry_s3     <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			item_vld_q <= item_vld_in;
			qry_s1     <= item_vld_q && (item_q.load == REQ_QUERY);
			qry_s2     <= qry_s1;
			qry_s3     <= qry_s2;
			best_vld_q <= qry_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_in;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (wr_hit && (item_q.axis == 3'(a))) begin
				lo_q[a] <= item_q.coord[SLOT_LOW];
				hi_q[a] <= item_q.coord[SLOT_HIGH];
			end
			gap_s1[a] <= gap_d[a];
			sq_s2[a]  <= SQ_W'(gap_s1[a]) * SQ_W'(gap_s1[a]);
		end
		for (int p = 0; p < NUM_AXES/2; p++) begin
			pair_s3[p] <= PAIR_W'(sq_s2[2*p]) + PAIR_W'(sq_s2[2*p+1]);
		end
		if (take) begin
			best_q.found <= 1'b1;
			best_q.total <= sum;
			best_q.idx   <= cell_idx;
		end else begin
			best_q <= best_in;
		end
	end

	assign item_vld_out = item_vld_q;
	assign item_out     = item_q;
	assign best_vld_out = best_vld_q;
	assign best_out     = best_q;

endmodule

### hdl/nearest_box_classifier_unit.sv
// Nearest box classifier. A beat is accepted at every rising edge at which start is high;
// busy stays low, so one beat can be accepted in every cycle. Load beats and query beats
// walk the same row of NUM_ENTRIES cells, one cell per cycle, so a load affects only the
// queries accepted after it. A query's result appears on the result ports, with done high,
// for exactly one cycle, once the query has passed one item register per cell along the row,
// the first of them loaded at the accepting edge itself, four stages in the last cell (gap,
// square, pair sum, total and compare) and one output register. Results leave in the order
// of the queries and cannot be held off, so the receiver must take every one.
// Load beats give no result. Configuration must only be written while no beat is still
// travelling the row, that is NUM_ENTRIES + 5 cycles after the last accepted beat. The
// box table has no reset value: every bound of an entry in use must be loaded before it
// is queried.
`include "nearest_box_classifier_unit_defines.svh"

module nearest_box_classifier_unit
	import nbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_wdata,

	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [4:0]         entry_index,
	input  logic [2:0]         axis_index,
	input  logic signed [15:0] bound_low,
	input  logic signed [15:0] bound_high,
	input  logic signed [15:0] coord_temperature,
	input  logic signed [15:0] coord_humidity,
	input  logic signed [15:0] coord_continent,
	input  logic signed [15:0] coord_erosion,
	input  logic signed [15:0] coord_ridge,
	input  logic signed [15:0] coord_weird,

	output logic               done,
	output logic [4:0]         class_index,
	output logic               contained,
	output logic [34:0]        best_distance
);

	// Edges from an accepted query to the edge that samples its result strobe.
	localparam int unsigned RES_LAT = NUM_ENTRIES + 5;

	// Configuration registers.
	logic [5:0] entries_q;
	logic [4:0] fallback_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= '0;
			fallback_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENTRIES_IN_USE: entries_q  <= cfg_wdata;
				REG_FALLBACK_CLASS: fallback_q <= cfg_wdata[4:0];
			endcase
		end
	end

	// The row never stalls, so a beat is taken whenever start is high.
	assign busy = 1'b0;

	// Chain links: element i feeds cell i, element i+1 is its output.
	logic  item_vld_c [NUM_ENTRIES+1];
	item_t item_c     [NUM_ENTRIES+1];
	logic  best_vld_c [NUM_ENTRIES+1];
	best_t best_c     [NUM_ENTRIES+1];
	logic  in_use_c   [NUM_ENTRIES];

	// A load beat carries its bound pair in the first two coordinate slots.
	always_comb begin
		item_vld_c[0]     = start && !busy;
		item_c[0].load    = req_type;
		item_c[0].entry   = entry_index;
		item_c[0].axis    = axis_index;
		item_c[0].coord[AXIS_TEMPERATURE] = COORD_BITS'(coord_temperature);
		item_c[0].coord[AXIS_HUMIDITY]    = COORD_BITS'(coord_humidity);
		item_c[0].coord[AXIS_CONTINENT]   = COORD_BITS'(coord_continent);
		item_c[0].coord[AXIS_EROSION]     = COORD_BITS'(coord_erosion);
		item_c[0].coord[AXIS_RIDGE]       = COORD_BITS'(coord_ridge);
		item_c[0].coord[AXIS_WEIRD]       = COORD_BITS'(coord_weird);
		if (req_type == REQ_LOAD) begin
			item_c[0].coord[SLOT_LOW]  = COORD_BITS'(bound_low);
			item_c[0].coord[SLOT_HIGH] = COORD_BITS'(bound_high);
		end
		// The first cell compares against an empty match.
		best_vld_c[0] = 1'b0;
		best_c[0]     = '0;
	end

	// Each cell holds one table entry. An entry takes part when its index lies below
	// the configured count, which also saturates the count at the size of the row.
	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
		assign in_use_c[i] = USE_W'(entries_q) > USE_W'(i);

		nbc_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_idx     (IDX_W'(i)),
			.in_use       (in_use_c[i]),
			.item_vld_in  (item_vld_c[i]),
			.item_in      (item_c[i]),
			.best_in      (best_c[i]),
			.item_vld_out (item_vld_c[i+1]),
			.item_out     (item_c[i+1]),
			.best_vld_out (best_vld_c[i+1]),
			.best_out     (best_c[i+1])
		);
	end

	// Output register. With no entry in use the fallback class is given with a zero
	// distance, and the point is never reported as contained.
	logic        done_q;
	logic [4:0]  class_q;
	logic        contained_q;
	logic [34:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= best_vld_c[NUM_ENTRIES];
		end
	end

	always_ff @(posedge clk) begin
		if (best_c[NUM_ENTRIES].found) begin
			class_q     <= 5'(best_c[NUM_ENTRIES].idx);
			contained_q <= (best_c[NUM_ENTRIES].total == '0);
			dist_q      <= 35'(best_c[NUM_ENTRIES].total);
		end else begin
			class_q     <= fallback_q;
			contained_q <= 1'b0;
			dist_q      <= '0;
		end
	end

	assign done          = done_q;
	assign class_index   = class_q;
	assign contained     = done_q && contained_q;
	assign best_distance = dist_q;

	// Every result beat comes from a query accepted a fixed number of edges earlier.
	`NBC_ASSERT_NOW(a_result_from_query, done, $past(start && !busy && (req_type == REQ_QUERY), RES_LAT), "result beat without matching query")
	// A contained point has a zero distance.
	`NBC_ASSERT_NOW(a_contained_zero, contained, done && (best_distance == '0), "contained with non-zero distance")
	// The running match of the first cell lines up with its query beat.
	`NBC_ASSERT_NOW(a_first_cell_skew, best_vld_c[1], $past(item_vld_c[1] && (item_c[1].load == REQ_QUERY), 4), "first cell match out of step")
	// The result register follows the last cell's query by its own fixed depth.
	`NBC_ASSERT_NEXT(a_last_cell_skew, best_vld_c[NUM_ENTRIES], done && $past(item_vld_c[NUM_ENTRIES] && (item_c[NUM_ENTRIES].load == REQ_QUERY), 5), "last cell match out of step")

endmodule
